/* rtl/fsp_pkg.sv */
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared constants and helper functions for the formation slot position block.
// ----------------------------------------------------------------------------
`default_nettype none

package fsp_pkg;

    // Robot count limit and output coordinate width
    localparam int FSP_MAX_ROBOTS  = 16;
    localparam int FSP_COORD_WIDTH = 32;

    // Ring lookup table size (angle index and ring size)
    localparam int FSP_TAB = 16;

    // Fixed point constants
    localparam logic [63:0] FSP_Q30_ONE  = 64'd1073741824;
    localparam logic [63:0] FSP_PI_Q30   = 64'd3373259426;
    localparam logic [63:0] FSP_HALF_OCT = 64'd536870912;

    // Reciprocals for the circle radius and the tenth
    localparam logic [63:0] FSP_RECIP_PI = (64'd1 << 61) / FSP_PI_Q30;
    localparam logic [63:0] FSP_RECIP_10 = (64'd1 << 34) / 64'd10;

    // Register indexes
    localparam logic FSP_REG_MODE    = 1'b0;
    localparam logic FSP_REG_SPACING = 1'b1;

    // Mode codes
    localparam logic [2:0] FSP_MODE_TRI    = 3'd0;
    localparam logic [2:0] FSP_MODE_LINE   = 3'd1;
    localparam logic [2:0] FSP_MODE_CIRCLE = 3'd2;
    localparam logic [2:0] FSP_MODE_SQUARE = 3'd3;
    localparam logic [2:0] FSP_MODE_V      = 3'd4;
    localparam logic [2:0] FSP_MODE_DYN    = 3'd5;

    // Cosine and sine of a phase (fraction of a turn), Q2.30, as {cos, sin}
    function automatic logic [63:0] f_trig(input logic [31:0] p);
        logic [2:0]         oct;
        logic [63:0]        r;
        logic [63:0]        a;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [31:0] s;
        logic signed [31:0] c;
        logic signed [31:0] cs;
        logic signed [31:0] sn;
        oct = p[31:29];
        r   = {35'd0, p[28:0]};
        a   = oct[0] ? (FSP_HALF_OCT - r) : r;
        x   = (a * FSP_PI_Q30) >> 31;
        x2  = (x * x) >> 30;
        t   = FSP_Q30_ONE;
        t   = FSP_Q30_ONE - (((x2 * t) >> 30) / 64'd72);
        t   = FSP_Q30_ONE - (((x2 * t) >> 30) / 64'd42);
        t   = FSP_Q30_ONE - (((x2 * t) >> 30) / 64'd20);
        t   = FSP_Q30_ONE - (((x2 * t) >> 30) / 64'd6);
        s   = 32'((x * t) >> 30);
        t   = FSP_Q30_ONE;
        t   = FSP_Q30_ONE - (((x2 * t) >> 30) / 64'd56);
        t   = FSP_Q30_ONE - (((x2 * t) >> 30) / 64'd30);
        t   = FSP_Q30_ONE - (((x2 * t) >> 30) / 64'd12);
        t   = FSP_Q30_ONE - (((x2 * t) >> 30) / 64'd2);
        c   = 32'(t);
        case (oct)
            3'd0:    begin cs = c;  sn = s;  end
            3'd1:    begin cs = s;  sn = c;  end
            3'd2:    begin cs = -s; sn = c;  end
            3'd3:    begin cs = -c; sn = s;  end
            3'd4:    begin cs = -c; sn = -s; end
            3'd5:    begin cs = -s; sn = -c; end
            3'd6:    begin cs = s;  sn = -c; end
            default: begin cs = c;  sn = -s; end
        endcase
        return {cs, sn};
    endfunction

    // Triangle ring of a slot: {ring number plus one, angle index, ring size minus one}
    function automatic logic [9:0] f_tri(input logic [3:0] i);
        logic [9:0] res;
        if (i < 4'd3) begin
            res = {2'd1, i, 4'd2};
        end else if (i < 4'd9) begin
            res = {2'd2, 4'(i - 4'd3), 4'd5};
        end else begin
            res = {2'd3, 4'(i - 4'd9), 4'd8};
        end
        return res;
    endfunction

    // Slot index divided by three
    function automatic logic [3:0] f_div3(input logic [3:0] i);
        logic [3:0] res;
        if (i < 4'd3)       res = 4'd0;
        else if (i < 4'd6)  res = 4'd1;
        else if (i < 4'd9)  res = 4'd2;
        else if (i < 4'd12) res = 4'd3;
        else if (i < 4'd15) res = 4'd4;
        else                res = 4'd5;
        return res;
    endfunction

    // Halve a signed value, rounding to nearest with ties away from zero
    function automatic logic signed [29:0] f_half(input logic signed [29:0] v);
        logic [29:0] mag;
        logic [29:0] h;
        mag = v[29] ? 30'(-v) : 30'(v);
        h   = (mag + 30'd1) >> 1;
        return v[29] ? -$signed(h) : $signed(h);
    endfunction

endpackage

`default_nettype wire

/* rtl/formation_slot_position.sv */
// ----------------------------------------------------------------------------
// formation_slot_position
// Places one formation slot per item: triangle rings, line, circle, square
// grid, V or a coherence-driven choice, in signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                                   | Direction
//  ---------+-------------------------------------------+----------
//  slot in  | i_in_valid / o_in_ready + slot fields     | in
//  target   | o_out_valid / i_out_ready + target fields | out
//  config   | psel penable pwrite paddr pwdata prdata   | APB
//
//  Six register stages; an item enters every cycle while the output is not
//  stalled. The depth is set by the circle radius reciprocal, its correction
//  and the radius times trig multiply. A stalled output freezes every stage
//  together, so nothing is lost or repeated. Reset (synchronous, active low)
//  clears the stage valid bits and loads the register defaults.
//
`default_nettype none

module formation_slot_position
    import fsp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [3:0]         i_slot_index,
    input  wire logic [4:0]         i_robot_total,
    input  wire logic signed [31:0] i_center_x,
    input  wire logic signed [31:0] i_center_y,
    input  wire logic [16:0]        i_mean_coherence,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_target_x,
    output logic signed [31:0]      o_target_y,
    output logic                    o_slot_valid,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    typedef enum logic [2:0] {
        SH_TRI,
        SH_LINE,
        SH_CIRCLE,
        SH_SQUARE,
        SH_V
    } t_shape;

    localparam logic signed [33:0] SAT_HI = 34'sd2147483647;
    localparam logic signed [33:0] SAT_LO = -34'sd2147483648;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0]  r_mode;
    logic [22:0] r_spacing;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= FSP_MODE_TRI;
            r_spacing <= 23'd131072;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                FSP_REG_MODE:    r_mode    <= pwdata[2:0];
                FSP_REG_SPACING: r_spacing <= pwdata[22:0];
                default:         r_mode    <= r_mode;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[2])
            FSP_REG_MODE:    prdata = {29'd0, r_mode};
            FSP_REG_SPACING: prdata = {9'd0, r_spacing};
            default:         prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Ring trig table, built at elaboration
    // ------------------------------------------------------------------
    logic signed [31:0] w_cos_tab [FSP_TAB][FSP_TAB];
    logic signed [31:0] w_sin_tab [FSP_TAB][FSP_TAB];

    for (genvar gK = 0; gK < FSP_TAB; gK++) begin : g_ring
        for (genvar gk = 0; gk < FSP_TAB; gk++) begin : g_ang
            localparam logic [63:0] PH   = (64'(gk) << 32) / 64'(gK + 1);
            localparam logic [63:0] TRIG = f_trig(PH[31:0]);
            assign w_cos_tab[gK][gk] = TRIG[63:32];
            assign w_sin_tab[gK][gk] = TRIG[31:0];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances when the output can move
    // ------------------------------------------------------------------
    logic       w_en;
    logic [6:1] r_vld;

    assign w_en        = !r_vld[6] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[5:1], i_in_valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: clamp count, pick shape, decode ring and grid position
    // ------------------------------------------------------------------
    logic [4:0]        w_n;
    logic              w_ok;
    t_shape            w_shape;
    logic [9:0]        w_tri;
    logic [2:0]        w_q;
    logic [3:0]        w_row;
    logic [3:0]        w_col;
    logic signed [5:0] w_lm;
    logic signed [5:0] w_sx;
    logic signed [5:0] w_sy;
    logic [4:0]        w_d5;

    t_shape            r1_shape;
    logic              r1_ok;
    logic signed [31:0] r1_cx;
    logic signed [31:0] r1_cy;
    logic [4:0]        r1_n;
    logic [1:0]        r1_l1;
    logic [3:0]        r1_k;
    logic [3:0]        r1_kk;
    logic signed [5:0] r1_mx;
    logic signed [5:0] r1_my;
    logic [3:0]        r1_d;
    logic              r1_odd;

    always_comb begin
        w_n  = (i_robot_total > 5'(FSP_MAX_ROBOTS)) ? 5'(FSP_MAX_ROBOTS) : i_robot_total;
        w_ok = {1'b0, i_slot_index} < w_n;
        case (r_mode)
            FSP_MODE_LINE:   w_shape = SH_LINE;
            FSP_MODE_CIRCLE: w_shape = SH_CIRCLE;
            FSP_MODE_SQUARE: w_shape = SH_SQUARE;
            FSP_MODE_V:      w_shape = SH_V;
            FSP_MODE_DYN: begin
                if (({3'd0, i_mean_coherence} * 20'd5) > 20'd262144) w_shape = SH_TRI;
                else if (i_mean_coherence > 17'd32768)              w_shape = SH_CIRCLE;
                else                                                 w_shape = SH_LINE;
            end
            default:         w_shape = SH_TRI;
        endcase
        w_tri = f_tri(i_slot_index);
        // Grid side: smallest q with q*q >= n
        if (w_n <= 5'd1)      w_q = 3'd1;
        else if (w_n <= 5'd4) w_q = 3'd2;
        else if (w_n <= 5'd9) w_q = 3'd3;
        else                  w_q = 3'd4;
        case (w_q)
            3'd1:    begin w_row = i_slot_index;              w_col = 4'd0; end
            3'd2:    begin w_row = {1'b0, i_slot_index[3:1]}; w_col = {3'd0, i_slot_index[0]}; end
            3'd3: begin
                w_row = f_div3(i_slot_index);
                w_col = 4'(i_slot_index - 4'(w_row * 4'd3));
            end
            default: begin w_row = {2'd0, i_slot_index[3:2]}; w_col = {2'd0, i_slot_index[1:0]}; end
        endcase
        w_lm = $signed({1'b0, i_slot_index, 1'b0}) - $signed({1'b0, w_n});
        w_sx = $signed({1'b0, w_col, 1'b0}) - $signed({3'd0, w_q});
        w_sy = $signed({1'b0, w_row, 1'b0}) - $signed({3'd0, w_q});
        w_d5 = {1'b0, i_slot_index} + 5'd1;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_shape <= w_shape;
            r1_ok    <= w_ok;
            r1_cx    <= i_center_x;
            r1_cy    <= i_center_y;
            r1_n     <= w_n;
            r1_l1    <= w_tri[9:8];
            r1_d     <= w_d5[4:1];
            r1_odd   <= i_slot_index[0];
            if (w_shape == SH_TRI) begin
                r1_k  <= w_tri[7:4];
                r1_kk <= w_tri[3:0];
            end else begin
                r1_k  <= i_slot_index;
                r1_kk <= 4'(w_n - 5'd1);
            end
            if (w_shape == SH_SQUARE) begin
                r1_mx <= w_sx;
                r1_my <= w_sy;
            end else begin
                r1_mx <= w_lm;
                r1_my <= 6'sd0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: trig lookup and spacing products
    // ------------------------------------------------------------------
    logic signed [29:0] w_s30;
    logic [6:0]         w_d7;

    t_shape             r2_shape;
    logic               r2_ok;
    logic signed [31:0] r2_cx;
    logic signed [31:0] r2_cy;
    logic signed [31:0] r2_cos;
    logic signed [31:0] r2_sin;
    logic [27:0]        r2_cxn;
    logic [24:0]        r2_trad;
    logic signed [29:0] r2_lx;
    logic signed [29:0] r2_ly;
    logic [29:0]        r2_v7;
    logic [26:0]        r2_w;
    logic               r2_odd;

    assign w_s30 = {7'd0, r_spacing};
    assign w_d7  = ({3'd0, r1_d} << 3) - {3'd0, r1_d};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_shape <= r1_shape;
            r2_ok    <= r1_ok;
            r2_cx    <= r1_cx;
            r2_cy    <= r1_cy;
            r2_odd   <= r1_odd;
            r2_cos   <= w_cos_tab[r1_kk][r1_k];
            r2_sin   <= w_sin_tab[r1_kk][r1_k];
            r2_cxn   <= 28'(r_spacing) * 28'(r1_n);
            r2_trad  <= 25'(r_spacing) * 25'(r1_l1);
            r2_lx    <= w_s30 * 30'(r1_mx);
            r2_ly    <= w_s30 * 30'(r1_my);
            r2_v7    <= 30'(r_spacing) * 30'(w_d7);
            r2_w     <= 27'(r_spacing) * 27'(r1_d);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: reciprocal estimates and halvings
    // ------------------------------------------------------------------
    logic [57:0] w_cprod;
    logic [29:0] w_v7p5;
    logic [61:0] w_vprod;
    logic [26:0] w_wing;

    t_shape             r3_shape;
    logic               r3_ok;
    logic signed [31:0] r3_cx;
    logic signed [31:0] r3_cy;
    logic signed [31:0] r3_cos;
    logic signed [31:0] r3_sin;
    logic [27:0]        r3_cxn;
    logic [24:0]        r3_qe;
    logic [24:0]        r3_trad;
    logic signed [29:0] r3_hx;
    logic signed [29:0] r3_hy;
    logic [29:0]        r3_v7p5;
    logic [25:0]        r3_vqe;
    logic [25:0]        r3_wing;
    logic               r3_odd;

    assign w_cprod = 58'(r2_cxn) * 58'(FSP_RECIP_PI);
    assign w_v7p5  = r2_v7 + 30'd5;
    assign w_vprod = 62'(w_v7p5) * 62'(FSP_RECIP_10);
    assign w_wing  = r2_w + 27'd1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_shape <= r2_shape;
            r3_ok    <= r2_ok;
            r3_cx    <= r2_cx;
            r3_cy    <= r2_cy;
            r3_cos   <= r2_cos;
            r3_sin   <= r2_sin;
            r3_odd   <= r2_odd;
            r3_cxn   <= r2_cxn;
            r3_qe    <= w_cprod[56:32];
            r3_trad  <= r2_trad;
            r3_hx    <= f_half(r2_lx);
            r3_hy    <= f_half(r2_ly);
            r3_v7p5  <= w_v7p5;
            r3_vqe   <= w_vprod[59:34];
            r3_wing  <= w_wing[26:1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: correct quotients, pick radius and straight offsets
    // ------------------------------------------------------------------
    logic [56:0]        w_rem;
    logic [25:0]        w_crad;
    logic [29:0]        w_vr;
    logic [25:0]        w_vq;
    logic signed [31:0] w_ox;
    logic signed [31:0] w_oy;

    logic               r4_ring;
    logic               r4_ok;
    logic signed [31:0] r4_cx;
    logic signed [31:0] r4_cy;
    logic signed [31:0] r4_cos;
    logic signed [31:0] r4_sin;
    logic [25:0]        r4_rad;
    logic signed [31:0] r4_ox;
    logic signed [31:0] r4_oy;

    always_comb begin
        w_rem  = {r3_cxn, 29'd0} - (57'(r3_qe) * 57'(FSP_PI_Q30));
        w_crad = (w_rem >= 57'(FSP_PI_Q30)) ? (26'(r3_qe) + 26'd1) : 26'(r3_qe);
        w_vr   = r3_v7p5 - (30'(r3_vqe) * 30'd10);
        w_vq   = (w_vr >= 30'd10) ? (r3_vqe + 26'd1) : r3_vqe;
        case (r3_shape)
            SH_V: begin
                w_ox = -$signed(32'(w_vq));
                w_oy = r3_odd ? -$signed(32'(r3_wing)) : $signed(32'(r3_wing));
            end
            default: begin
                w_ox = 32'(r3_hx);
                w_oy = 32'(r3_hy);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_ring <= (r3_shape == SH_TRI) || (r3_shape == SH_CIRCLE);
            r4_ok   <= r3_ok;
            r4_cx   <= r3_cx;
            r4_cy   <= r3_cy;
            r4_cos  <= r3_cos;
            r4_sin  <= r3_sin;
            r4_rad  <= (r3_shape == SH_TRI) ? 26'(r3_trad) : w_crad;
            r4_ox   <= w_ox;
            r4_oy   <= w_oy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: radius times cosine and sine magnitudes
    // ------------------------------------------------------------------
    logic [30:0] w_cmag;
    logic [30:0] w_smag;

    logic               r5_ring;
    logic               r5_ok;
    logic signed [31:0] r5_cx;
    logic signed [31:0] r5_cy;
    logic [56:0]        r5_px;
    logic [56:0]        r5_py;
    logic               r5_nx;
    logic               r5_ny;
    logic signed [31:0] r5_ox;
    logic signed [31:0] r5_oy;

    assign w_cmag = r4_cos[31] ? 31'(-r4_cos) : 31'(r4_cos);
    assign w_smag = r4_sin[31] ? 31'(-r4_sin) : 31'(r4_sin);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_ring <= r4_ring;
            r5_ok   <= r4_ok;
            r5_cx   <= r4_cx;
            r5_cy   <= r4_cy;
            r5_px   <= 57'(r4_rad) * 57'(w_cmag);
            r5_py   <= 57'(r4_rad) * 57'(w_smag);
            r5_nx   <= r4_cos[31];
            r5_ny   <= r4_sin[31];
            r5_ox   <= r4_ox;
            r5_oy   <= r4_oy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: round, add center, saturate, hold for the consumer
    // ------------------------------------------------------------------
    logic [56:0]        w_rx;
    logic [56:0]        w_ry;
    logic signed [33:0] w_dx;
    logic signed [33:0] w_dy;
    logic signed [33:0] w_sx34;
    logic signed [33:0] w_sy34;

    always_comb begin
        w_rx = (r5_px + 57'd536870912) >> 30;
        w_ry = (r5_py + 57'd536870912) >> 30;
        if (!r5_ok) begin
            w_dx = 34'sd0;
            w_dy = 34'sd0;
        end else if (r5_ring) begin
            w_dx = r5_nx ? -$signed(34'(w_rx)) : $signed(34'(w_rx));
            w_dy = r5_ny ? -$signed(34'(w_ry)) : $signed(34'(w_ry));
        end else begin
            w_dx = 34'(r5_ox);
            w_dy = 34'(r5_oy);
        end
        w_sx34 = 34'(r5_cx) + w_dx;
        w_sy34 = 34'(r5_cy) + w_dy;
        if (w_sx34 > SAT_HI)      w_sx34 = SAT_HI;
        else if (w_sx34 < SAT_LO) w_sx34 = SAT_LO;
        if (w_sy34 > SAT_HI)      w_sy34 = SAT_HI;
        else if (w_sy34 < SAT_LO) w_sy34 = SAT_LO;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_target_x   <= w_sx34[31:0];
            o_target_y   <= w_sy34[31:0];
            o_slot_valid <= r5_ok;
        end
    end

endmodule

`default_nettype wire

/* rtl/fsp_checker.sv */
// ----------------------------------------------------------------------------
// fsp_checker
// Port-level checks for the formation slot position block.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_target_x,
    input wire logic [31:0] o_target_y,
    input wire logic        o_slot_valid,
    input wire logic        pready
);

    // Hold a waiting item until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output item dropped while stalled");

    // Hold the payload of a waiting item
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_target_x) && $stable(o_target_y) && $stable(o_slot_valid))
        else $error("output payload changed while stalled");

    // Stall the input only behind a stalled output
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output backpressure");

    // Drop all items at reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Complete every register access at once
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("register access wait state");

endmodule

bind formation_slot_position fsp_checker u_fsp_checker (.*);

`default_nettype wire

/* tb/slot_target_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_target_checker
// Watches the slot and target channels and the register port, computes the
// target point of every accepted slot item and compares it with what leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_target_checker
    import fsp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic [3:0]         i_slot_index,
    input  wire logic [4:0]         i_robot_total,
    input  wire logic signed [31:0] i_center_x,
    input  wire logic signed [31:0] i_center_y,
    input  wire logic [16:0]        i_mean_coherence,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic signed [31:0] i_target_x,
    input  wire logic signed [31:0] i_target_y,
    input  wire logic               i_slot_valid,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic               i_pready,
    input  wire logic [2:0]         i_paddr,
    input  wire logic [31:0]        i_pwdata,
    output int                      o_errors,
    output int                      o_pending
);

    localparam longint unsigned Q30 = 64'd1073741824;
    localparam longint unsigned PIQ = 64'd3373259426;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               ok;
    } target_t;

    logic [2:0]  mode_q;
    logic [22:0] spacing_q;
    target_t     targets_due[$];

    // Round num/den to nearest, ties away from zero
    function automatic longint rnd_div(input longint num, input longint den);
        longint mag;
        mag = num < 0 ? -num : num;
        mag = (mag + den / 2) / den;
        return num < 0 ? -mag : mag;
    endfunction

    function automatic longint unsigned taylor(input longint unsigned x2,
                                               input longint unsigned t,
                                               input longint unsigned d);
        return Q30 - (((x2 * t) >> 30) / d);
    endfunction

    // Point at angle k/kk of a turn on radius rad
    function automatic void ring_point(input longint unsigned rad,
                                       input longint unsigned k,
                                       input longint unsigned kk,
                                       output longint dx, output longint dy);
        logic [31:0] ph;
        logic [2:0]  oc;
        longint unsigned a, x, x2, t, tm;
        longint s, c, cs, sn;
        ph = 32'((k << 32) / kk);
        oc = ph[31:29];
        a  = oc[0] ? 64'd536870912 - ph[28:0] : ph[28:0];
        x  = (a * PIQ) >> 31;
        x2 = (x * x) >> 30;
        t = Q30;
        t = taylor(x2, t, 72); t = taylor(x2, t, 42);
        t = taylor(x2, t, 20); t = taylor(x2, t, 6);
        s = longint'((x * t) >> 30);
        t = Q30;
        t = taylor(x2, t, 56); t = taylor(x2, t, 30);
        t = taylor(x2, t, 12); t = taylor(x2, t, 2);
        c = longint'(t);
        case (oc)
            3'd0: begin cs = c;  sn = s;  end
            3'd1: begin cs = s;  sn = c;  end
            3'd2: begin cs = -s; sn = c;  end
            3'd3: begin cs = -c; sn = s;  end
            3'd4: begin cs = -c; sn = -s; end
            3'd5: begin cs = -s; sn = -c; end
            3'd6: begin cs = s;  sn = -c; end
            default: begin cs = c; sn = -s; end
        endcase
        tm = cs < 0 ? -cs : cs;
        dx = longint'((rad * tm + (Q30 >> 1)) >> 30);
        if (cs < 0) dx = -dx;
        tm = sn < 0 ? -sn : sn;
        dy = longint'((rad * tm + (Q30 >> 1)) >> 30);
        if (sn < 0) dy = -dy;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // Compute the target point of one slot item
    function automatic target_t slot_target(input logic [3:0] idx,
                                            input logic [4:0] cnt,
                                            input logic signed [31:0] cx,
                                            input logic signed [31:0] cy,
                                            input logic [16:0] coh);
        target_t     r;
        longint      dx, dy, sp, i, n, lay, q, d, w;
        logic [2:0]  m;
        dx = 0; dy = 0;
        sp = spacing_q;
        i  = idx;
        n  = cnt > 16 ? 16 : cnt;
        r.ok = i < n;
        m = mode_q;
        if (m == FSP_MODE_DYN) begin
            if (coh * 5 > 4 * 65536) m = FSP_MODE_TRI;
            else if (coh > 32768) m = FSP_MODE_CIRCLE;
            else m = FSP_MODE_LINE;
        end
        if (r.ok) begin
            case (m)
                FSP_MODE_LINE: dx = rnd_div(sp * (2 * i - n), 2);
                FSP_MODE_CIRCLE:
                    ring_point(((sp * n) << 29) / PIQ, i, n, dx, dy);
                FSP_MODE_SQUARE: begin
                    q = 1;
                    while (q * q < n) q++;
                    dx = rnd_div(sp * (2 * (i % q) - q), 2);
                    dy = rnd_div(sp * (2 * (i / q) - q), 2);
                end
                FSP_MODE_V: if (i != 0) begin
                    d  = (i + 1) / 2;
                    w  = rnd_div(sp * d, 2);
                    dx = -rnd_div(sp * d * 7, 10);
                    dy = (i % 2 == 0) ? w : -w;
                end
                default: begin
                    lay = 0;
                    while (i >= 3 * (lay + 1)) begin
                        i -= 3 * (lay + 1);
                        lay++;
                    end
                    ring_point(sp * (lay + 1), i, 3 * (lay + 1), dx, dy);
                end
            endcase
        end
        r.x = clamp32(longint'(cx) + dx);
        r.y = clamp32(longint'(cy) + dy);
        return r;
    endfunction

    assign o_pending = targets_due.size();

    // Track registers, queue predictions, compare results
    always @(posedge i_clk) begin
        target_t e;
        if (!i_rst_n) begin
            mode_q    <= FSP_MODE_TRI;
            spacing_q <= 23'd131072;
            targets_due.delete();
            o_errors  <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == FSP_REG_MODE) mode_q <= i_pwdata[2:0];
                else spacing_q <= i_pwdata[22:0];
            end
            if (i_in_valid && i_in_ready)
                targets_due = {targets_due, slot_target(i_slot_index, i_robot_total,
                    i_center_x, i_center_y, i_mean_coherence)};
            if (i_out_valid && i_out_ready) begin
                if (targets_due.size() == 0) begin
                    $display("%0t: target item with none expected: %h %h %b", $realtime,
                             i_target_x, i_target_y, i_slot_valid);
                    o_errors <= o_errors + 1;
                end else begin
                    e = targets_due.pop_front();
                    if (e !== {i_target_x, i_target_y, i_slot_valid}) begin
                        $display("%0t: target mismatch: expected x=%h y=%h v=%b got x=%h y=%h v=%b",
                                 $realtime, e.x, e.y, e.ok, i_target_x, i_target_y,
                                 i_slot_valid);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives slot items and register writes into the formation slot block across
// all modes and spacing extremes, with random idling and a long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import fsp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [3:0]         i_slot_index = '0;
    logic [4:0]         i_robot_total = 5'd1;
    logic signed [31:0] i_center_x = '0;
    logic signed [31:0] i_center_y = '0;
    logic [16:0]        i_mean_coherence = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_target_x;
    logic signed [31:0] o_target_y;
    logic               o_slot_valid;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    int                 mismatches;
    int                 in_flight;
    int                 cycles = 0;
    bit                 calm = 1'b0;
    bit                 hold_off = 1'b0;

    formation_slot_position dut (.*);

    slot_target_checker chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_slot_index,
        .i_robot_total, .i_center_x, .i_center_y, .i_mean_coherence,
        .i_out_valid(o_out_valid), .i_out_ready, .i_target_x(o_target_x),
        .i_target_y(o_target_y), .i_slot_valid(o_slot_valid), .i_psel(psel),
        .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_errors(mismatches),
        .o_pending(in_flight)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stalls, none while calm, long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= !hold_off && (calm || $urandom_range(99) >= 15);
    end

    task automatic reg_write(input logic idx, input logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop the input valid and wait until every item has left
    task automatic drain;
        i_in_valid <= 1'b0;
        while (in_flight != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Offer one slot item and wait for acceptance
    task automatic send_slot(input logic [3:0] idx, input logic [4:0] cnt,
                             input logic [31:0] cx, input logic [31:0] cy,
                             input logic [16:0] coh);
        while (!calm && $urandom_range(99) < 15) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_slot_index <= idx; i_robot_total <= cnt;
        i_center_x <= cx; i_center_y <= cy; i_mean_coherence <= coh;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic logic [31:0] rand_center;
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7FFF_FF00 : 32'h8000_0100;
            default: return 32'($signed($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    task automatic random_slots(input int count);
        for (int k = 0; k < count; k++)
            send_slot(4'($urandom), $urandom_range(9) == 0 ? 5'($urandom) :
                      5'($urandom_range(16, 1)), rand_center(), rand_center(),
                      $urandom_range(9) == 0 ? 17'($urandom) : 17'($urandom_range(65536)));
    endtask

    initial begin
        logic [22:0] spacings[4];
        spacings = '{23'd0, 23'd4194304, 23'h7FFFFF, 23'd98304};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: default triangle, extremes of every field
        send_slot(4'd0, 5'd1, 32'h0, 32'h0, 17'd0);
        send_slot(4'd15, 5'd16, 32'h7FFF_FFFF, 32'h8000_0000, 17'h1FFFF);
        send_slot(4'd2, 5'd0, 32'h1234_5678, 32'hFFFF_FFFF, 17'd65536);
        send_slot(4'd9, 5'd31, 32'h8000_0000, 32'h7FFF_FFFF, 17'd52429);
        send_slot(4'd5, 5'd5, 32'h0001_0000, 32'hFFFF_0000, 17'd52428);
        drain();

        // Every mode, incl. unused codes, with spacing extremes
        for (int m = 0; m < 8; m++) begin
            reg_write(FSP_REG_MODE, 32'(m));
            reg_write(FSP_REG_SPACING, {9'd0, spacings[m % 4]});
            send_slot(4'd0, 5'd16, 32'h0, 32'h0, 17'd32768);
            send_slot(4'd7, 5'd9, 32'h7FFF_0000, 32'h8001_0000, 17'd32769);
            send_slot(4'd15, 5'd17, 32'hFFFF_FFFF, 32'h0, 17'd65536);
            drain();
        end

        // Long output hold-off while items keep coming
        hold_off = 1'b1;
        fork
            random_slots(40);
            begin
                repeat (150) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
        drain();

        // Random phases over settings, one calm stretch
        for (int ph = 0; ph < 8; ph++) begin
            reg_write(FSP_REG_MODE, ph < 6 ? 32'(ph) : 32'($urandom_range(7)));
            reg_write(FSP_REG_SPACING, ph == 6 ? 32'd4194304 :
                      32'($urandom_range(4194304)));
            calm = (ph == 3);
            random_slots(50);
            drain();
        end
        calm = 1'b0;

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
